### rtl/lrcp_pkg.sv
// Shared types, widths and register indexes for the line/rectangle clip block.
`default_nettype none

package lrcp_pkg;

  // Field and datapath widths.
  localparam int unsigned CoordW   = 32;
  localparam int unsigned EpsW     = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned NumMagW  = 65;
  localparam int unsigned DenMagW  = 64;
  localparam int unsigned DltMagW  = 33;
  localparam int unsigned NumerW   = 99;
  localparam int unsigned DivW     = 65;
  localparam int unsigned QuoW     = 41;
  localparam int unsigned SumW     = 42;

  // Registers in one edge unit from input to result.
  localparam int unsigned EdgeLatency = QuoW + 4;

  // Default depth of the queue between front and back.
  localparam int unsigned QueueDepthDef = 4;

  // Configuration register indexes.
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t CfgRectXLow  = 3'd0;
  localparam cfg_idx_t CfgRectXHigh = 3'd1;
  localparam cfg_idx_t CfgRectYLow  = 3'd2;
  localparam cfg_idx_t CfgRectYHigh = 3'd3;
  localparam cfg_idx_t CfgDenEps    = 3'd4;

  // Rectangle and epsilon settings as seen by the datapath.
  typedef struct packed {
    logic signed [CoordW-1:0] x_low;
    logic signed [CoordW-1:0] x_high;
    logic signed [CoordW-1:0] y_low;
    logic signed [CoordW-1:0] y_high;
    logic [EpsW-1:0]          eps;
  } rect_cfg_t;

  // One classified edge, ready for interpolation.
  typedef struct packed {
    logic                     hit;
    logic                     neg;
    logic [NumMagW-1:0]       num_mag;
    logic [DenMagW-1:0]       den_mag;
    logic [DltMagW-1:0]       dlt_mag;
    logic signed [CoordW-1:0] base;
    logic signed [CoordW-1:0] fix_c;
  } edge_t;

  // One queued line: bottom, right, top, left.
  typedef edge_t [3:0] entry_t;

endpackage

`default_nettype wire

### rtl/line_rectangle_clip_points_top.sv
// Top level of the line/rectangle clip block: configuration registers and wiring.
//
// Takes one line (pivot and normal, Q16.16) per cycle unless stalled and returns where it
// crosses the bottom, right, top and left edges of the configured rectangle, one result
// per line in order. Throughput is one line per clock when nothing stalls. A line passes
// 51 registers: four front stages, the queue write, 45 stages in each edge unit (41 of
// them the quotient pipeline) and the output register. A four-entry queue between the
// front and back parts absorbs short output stalls. Write configuration only while idle.
`default_nettype none

module line_rectangle_clip_points_top import lrcp_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire cfg_idx_t                 cfg_index_i,
  input  wire logic [CoordW-1:0]        cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [CoordW-1:0] pivot_x_i,
  input  wire logic signed [CoordW-1:0] pivot_y_i,
  input  wire logic signed [CoordW-1:0] dir_x_i,
  input  wire logic signed [CoordW-1:0] dir_y_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          both_found_o,
  output logic [2:0]                    hit_count_o,
  output logic signed [CoordW-1:0]      first_x_o,
  output logic signed [CoordW-1:0]      first_y_o,
  output logic signed [CoordW-1:0]      second_x_o,
  output logic signed [CoordW-1:0]      second_y_o
);

  rect_cfg_t cfg_q;
  logic      push, full, pop, empty;
  entry_t    q_in, q_out;

  assign cfg_ready_o = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_low  <= 32'sd0;
      cfg_q.x_high <= 32'sd65536;
      cfg_q.y_low  <= 32'sd0;
      cfg_q.y_high <= 32'sd65536;
      cfg_q.eps    <= 17'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgRectXLow:  cfg_q.x_low  <= cfg_data_i;
        CfgRectXHigh: cfg_q.x_high <= cfg_data_i;
        CfgRectYLow:  cfg_q.y_low  <= cfg_data_i;
        CfgRectYHigh: cfg_q.y_high <= cfg_data_i;
        CfgDenEps:    cfg_q.eps    <= cfg_data_i[EpsW-1:0];
        default: begin
        end
      endcase
    end
  end

  lrcp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pivot_x_i  (pivot_x_i),
    .pivot_y_i  (pivot_y_i),
    .dir_x_i    (dir_x_i),
    .dir_y_i    (dir_y_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (q_in)
  );

  lrcp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_out)
  );

  lrcp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (q_out),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .both_found_o (both_found_o),
    .hit_count_o  (hit_count_o),
    .first_x_o    (first_x_o),
    .first_y_o    (first_y_o),
    .second_x_o   (second_x_o),
    .second_y_o   (second_y_o)
  );

endmodule

`default_nettype wire

### rtl/lrcp_front.sv
// Front part: accepts lines, forms numerators and denominators, classifies hits.
`default_nettype none

module lrcp_front import lrcp_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire rect_cfg_t                cfg_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [CoordW-1:0] pivot_x_i,
  input  wire logic signed [CoordW-1:0] pivot_y_i,
  input  wire logic signed [CoordW-1:0] dir_x_i,
  input  wire logic signed [CoordW-1:0] dir_y_i,
  input  wire logic                     full_i,
  output logic                          push_o,
  output entry_t                        entry_o
);

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [CoordW-1:0] px_q, py_q, dx_q, dy_q;
  logic signed [32:0] dpxl, dpyl, dpxh, dpyh, dw, dh;
  logic signed [64:0] pxl_q, pyl_q, pxh_q, pyh_q, pw_q, ph_q;
  logic signed [32:0] dw_q, dh_q, dw3_q, dh3_q;
  logic signed [64:0] pw3_q, ph3_q;
  logic signed [65:0] numl_q, numh_q;
  logic [32:0] epsv;
  entry_t entry_d, entry_q;

  // Classify one edge: magnitudes, epsilon floor and the exact range test.
  function automatic edge_t make_edge(input logic signed [65:0] num,
                                      input logic signed [65:0] den,
                                      input logic signed [33:0] dlt,
                                      input logic signed [CoordW-1:0] base,
                                      input logic signed [CoordW-1:0] fixc,
                                      input logic [32:0] ev);
    edge_t e;
    logic [65:0] nabs, dabs;
    logic [33:0] labs;
    logic [63:0] dmag;
    nabs = num[65] ? 66'(-num) : 66'(num);
    dabs = den[65] ? 66'(-den) : 66'(den);
    labs = dlt[33] ? 34'(-dlt) : 34'(dlt);
    dmag = (dabs[63:0] <= 64'(ev)) ? 64'(ev) : dabs[63:0];
    e.hit     = (nabs == 66'd0) ||
                ((num[65] == den[65]) && (nabs[64:0] <= 65'(dmag)));
    e.neg     = num[65] ^ dlt[33] ^ den[65];
    e.num_mag = nabs[64:0];
    e.den_mag = dmag;
    e.dlt_mag = labs[32:0];
    e.base    = base;
    e.fix_c   = fixc;
    return e;
  endfunction

  // The whole front moves together unless the last stage waits on a full queue.
  assign adv        = !(v4_q && full_i);
  assign in_stall_o = !adv;
  assign push_o     = v4_q && !full_i;
  assign entry_o    = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Differences from the corners, ready for the products.
  always_comb begin
    dpxl = 33'(px_q) - 33'(cfg_i.x_low);
    dpyl = 33'(py_q) - 33'(cfg_i.y_low);
    dpxh = 33'(px_q) - 33'(cfg_i.x_high);
    dpyh = 33'(py_q) - 33'(cfg_i.y_high);
    dw   = 33'(cfg_i.x_high) - 33'(cfg_i.x_low);
    dh   = 33'(cfg_i.y_low) - 33'(cfg_i.y_high);
  end

  // Epsilon in Q32.32, with zero read as one.
  assign epsv = {((cfg_i.eps == '0) ? 17'd1 : cfg_i.eps), 16'd0};

  // The last front stage builds the bottom, right, top and left edge records.
  always_comb begin
    entry_d[0] = make_edge(numl_q, 66'(pw3_q), 34'(dw3_q),
                           cfg_i.x_low, cfg_i.y_low, epsv);
    entry_d[1] = make_edge(numh_q, 66'(ph3_q), 34'(dh3_q),
                           cfg_i.y_high, cfg_i.x_high, epsv);
    entry_d[2] = make_edge(numh_q, -66'(pw3_q), -34'(dw3_q),
                           cfg_i.x_high, cfg_i.y_high, epsv);
    entry_d[3] = make_edge(numl_q, -66'(ph3_q), -34'(dh3_q),
                           cfg_i.y_low, cfg_i.x_low, epsv);
  end

  // Payload pipeline: inputs, products, sums, classified edges.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q    <= pivot_x_i;
      py_q    <= pivot_y_i;
      dx_q    <= dir_x_i;
      dy_q    <= dir_y_i;
      pxl_q   <= 65'(dpxl) * 65'(dx_q);
      pyl_q   <= 65'(dpyl) * 65'(dy_q);
      pxh_q   <= 65'(dpxh) * 65'(dx_q);
      pyh_q   <= 65'(dpyh) * 65'(dy_q);
      pw_q    <= 65'(dw) * 65'(dx_q);
      ph_q    <= 65'(dh) * 65'(dy_q);
      dw_q    <= dw;
      dh_q    <= dh;
      numl_q  <= 66'(pxl_q) + 66'(pyl_q);
      numh_q  <= 66'(pxh_q) + 66'(pyh_q);
      pw3_q   <= pw_q;
      ph3_q   <= ph_q;
      dw3_q   <= dw_q;
      dh3_q   <= dh_q;
      entry_q <= entry_d;
    end
  end

endmodule

`default_nettype wire

### rtl/lrcp_queue.sv
// Short queue of classified lines between the front and the back part.
`default_nettype none

module lrcp_queue import lrcp_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t data_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        empty_o,
  output entry_t      data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("Queue fill count exceeds its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("Queue fill count did not follow a lone push.");

endmodule

`default_nettype wire

### rtl/lrcp_edge.sv
// One edge unit: scaled numerator, rounded quotient pipeline and saturated point.
`default_nettype none

module lrcp_edge import lrcp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire edge_t        edge_i,
  output logic              hit_o,
  output logic [CoordW-1:0] var_o,
  output logic [CoordW-1:0] fix_o
);

  typedef struct packed {
    logic                     hit;
    logic                     neg;
    logic signed [CoordW-1:0] base;
    logic signed [CoordW-1:0] fix_c;
  } side_t;

  logic [65:0]        pp_lo_q;
  logic [64:0]        pp_hi_q;
  logic [DenMagW-1:0] den_s0_q;
  side_t              side_s0_q, side_s1_q;
  logic [NumerW-1:0]  n_q;
  logic [DivW-1:0]    d_s1_q;

  logic [DivW-1:0] rem_q  [QuoW+1];
  logic [QuoW-1:0] nlo_q  [QuoW+1];
  logic [DivW-1:0] dd_q   [QuoW+1];
  logic [QuoW-1:0] quo_q  [QuoW+1];
  logic            ovf_q  [QuoW+1];
  side_t           side_q [QuoW+1];

  logic [QuoW-1:0]        qq;
  logic signed [SumW-1:0] sum;
  logic                   clamp;
  logic [CoordW-1:0]      var_d;
  logic                   hit_q;
  logic [CoordW-1:0]      var_q, fix_q;

  assign hit_o = hit_q;
  assign var_o = var_q;
  assign fix_o = fix_q;

  // Partial products, then numerator 2*|num|*|delta| + |den| and divisor 2*|den|.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_lo_q   <= 66'(edge_i.num_mag[32:0]) * 66'(edge_i.dlt_mag);
      pp_hi_q   <= 65'(edge_i.num_mag[64:33]) * 65'(edge_i.dlt_mag);
      den_s0_q  <= edge_i.den_mag;
      side_s0_q <= '{hit: edge_i.hit, neg: edge_i.neg, base: edge_i.base,
                     fix_c: edge_i.fix_c};
      n_q       <= (NumerW'(pp_lo_q) << 1) + (NumerW'(pp_hi_q) << 34) +
                   NumerW'(den_s0_q);
      d_s1_q    <= {den_s0_q, 1'b0};
      side_s1_q <= side_s0_q;
      // Quotient above the clamp range shows up as a top remainder at or over d.
      rem_q[0]  <= DivW'(n_q[NumerW-1:QuoW]);
      nlo_q[0]  <= n_q[QuoW-1:0];
      dd_q[0]   <= d_s1_q;
      quo_q[0]  <= '0;
      ovf_q[0]  <= (DivW'(n_q[NumerW-1:QuoW]) >= d_s1_q);
      side_q[0] <= side_s1_q;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar j = 1; j <= QuoW; j++) begin : g_div
    logic [DivW:0] trial, diff;
    logic          ge;

    always_comb begin
      trial = {rem_q[j-1], nlo_q[j-1][QuoW-j]};
      diff  = trial - {1'b0, dd_q[j-1]};
      ge    = (trial >= {1'b0, dd_q[j-1]});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
        nlo_q[j]  <= nlo_q[j-1];
        dd_q[j]   <= dd_q[j-1];
        quo_q[j]  <= {quo_q[j-1][QuoW-2:0], ge};
        ovf_q[j]  <= ovf_q[j-1];
        side_q[j] <= side_q[j-1];
      end
    end
  end

  // Clamp the offset, apply it to the corner and saturate to 32 bits.
  always_comb begin
    clamp = ovf_q[QuoW] || (quo_q[QuoW][QuoW-1] && (|quo_q[QuoW][QuoW-2:0]));
    qq    = clamp ? {1'b1, {(QuoW-1){1'b0}}} : quo_q[QuoW];
    sum   = side_q[QuoW].neg ? SumW'(side_q[QuoW].base) - SumW'({1'b0, qq})
                             : SumW'(side_q[QuoW].base) + SumW'({1'b0, qq});
    if (sum[SumW-1:CoordW-1] == '0 || sum[SumW-1:CoordW-1] == '1) begin
      var_d = sum[CoordW-1:0];
    end else begin
      var_d = sum[SumW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= side_q[QuoW].hit;
      var_q <= var_d;
      fix_q <= side_q[QuoW].fix_c;
    end
  end

endmodule

`default_nettype wire

### rtl/lrcp_back.sv
// Back part: the bottom, right, top and left edge units, hit ordering and the output register.
`default_nettype none

module lrcp_back import lrcp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire entry_t       entry_i,
  input  wire logic         empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic              both_found_o,
  output logic [2:0]        hit_count_o,
  output logic [CoordW-1:0] first_x_o,
  output logic [CoordW-1:0] first_y_o,
  output logic [CoordW-1:0] second_x_o,
  output logic [CoordW-1:0] second_y_o
);

  logic adv;
  logic [EdgeLatency-1:0] vld_q;
  logic [3:0] hit;
  logic [CoordW-1:0] var_c [4];
  logic [CoordW-1:0] fix_c [4];
  logic [CoordW-1:0] ex [4];
  logic [CoordW-1:0] ey [4];
  logic [2:0] cnt;
  logic [1:0] first_idx, last_idx;
  logic out_valid_q, both_q;
  logic [2:0] cnt_q;
  logic [CoordW-1:0] fx_q, fy_q, sx_q, sy_q;

  // Everything moves unless a finished result is held by the receiver.
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !empty_i;

  for (genvar k = 0; k < 4; k++) begin : g_edge
    lrcp_edge u_edge (
      .clk_i  (clk_i),
      .en_i   (adv),
      .edge_i (entry_i[k]),
      .hit_o  (hit[k]),
      .var_o  (var_c[k]),
      .fix_o  (fix_c[k])
    );
    // Bottom and top interpolate x; right and left interpolate y.
    assign ex[k] = (k % 2 == 0) ? var_c[k] : fix_c[k];
    assign ey[k] = (k % 2 == 0) ? fix_c[k] : var_c[k];
  end

  // Valid bits follow the edge units stage by stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[EdgeLatency-2:0], !empty_i};
      out_valid_q <= vld_q[EdgeLatency-1];
    end
  end

  // First hit in edge order and the last later one.
  always_comb begin
    cnt       = 3'(hit[0]) + 3'(hit[1]) + 3'(hit[2]) + 3'(hit[3]);
    first_idx = 2'd0;
    last_idx  = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (hit[k]) begin
        first_idx = 2'(k);
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (hit[k]) begin
        last_idx = 2'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      both_q <= (cnt >= 3'd2);
      cnt_q  <= cnt;
      fx_q   <= (cnt != 3'd0) ? ex[first_idx] : '0;
      fy_q   <= (cnt != 3'd0) ? ey[first_idx] : '0;
      sx_q   <= (cnt >= 3'd2) ? ex[last_idx] : '0;
      sy_q   <= (cnt >= 3'd2) ? ey[last_idx] : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign both_found_o = both_q;
  assign hit_count_o  = cnt_q;
  assign first_x_o    = fx_q;
  assign first_y_o    = fy_q;
  assign second_x_o   = sx_q;
  assign second_y_o   = sy_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> (both_found_o == (hit_count_o >= 3'd2)))
    else $error("Both-found flag disagrees with the hit count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> (hit_count_o <= 3'd4))
    else $error("Hit count above four.");

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the line/rectangle clip block.
`default_nettype none

module tb_top;
  import lrcp_pkg::*;

  // Exact line/edge intersection arithmetic, kept at generous widths.
  typedef logic signed [127:0] wide_t;

  // One line and one crossing summary.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } line_t;

  typedef struct packed {
    logic               both;
    logic [2:0]         hits;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
  } crossing_t;

  localparam int unsigned LatencyCycles = 80;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned HoldCycles    = 300;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  cfg_idx_t cfg_index_i;
  logic [31:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [31:0] pivot_x_i, pivot_y_i, dir_x_i, dir_y_i;
  logic out_valid_o;
  logic out_stall_i;
  logic both_found_o;
  logic [2:0] hit_count_o;
  logic signed [31:0] first_x_o, first_y_o, second_x_o, second_y_o;

  line_rectangle_clip_points_top dut (.*);

  // Shadow of the rectangle and epsilon settings.
  logic signed [31:0] xlo_q, xhi_q, ylo_q, yhi_q;
  logic [16:0] eps_q;

  line_t     pending_lines[$];
  crossing_t expected_crossings[$];
  int        error_count = 0;
  int        idle_cycles;
  bit        quiet_sender;
  bit        quiet_receiver;
  bit        hold_request;
  bit        hold_taken = 1'b0;
  int        hold_left = 0;
  logic      in_stall_q;

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Interpolates one coordinate: a + num*delta/den, rounded half away from zero, saturated.
  function automatic logic signed [31:0] interpolate(input logic signed [31:0] a,
                                                     input wide_t num, input wide_t delta,
                                                     input wide_t den);
    wide_t prod, n, d, q, r;
    bit neg;
    prod = num * delta;
    neg  = (prod < 0) != (den < 0);
    n    = (prod < 0) ? -prod : prod;
    d    = (den < 0) ? -den : den;
    q    = (2 * n + d) / (2 * d);
    if (q > (wide_t'(1) <<< 40)) q = wide_t'(1) <<< 40;
    r = neg ? wide_t'(a) - q : wide_t'(a) + q;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // Works out the crossing summary of a line against the current rectangle.
  function automatic crossing_t clip_line(input line_t ln);
    crossing_t res;
    wide_t ax[4], ay[4], bx[4], by[4];
    wide_t num, den, eps;
    logic signed [31:0] hx, hy;
    bit hit;
    res = '0;
    ax[0] = xlo_q; ay[0] = ylo_q; bx[0] = xhi_q; by[0] = ylo_q;
    ax[1] = xhi_q; ay[1] = yhi_q; bx[1] = xhi_q; by[1] = ylo_q;
    ax[2] = xhi_q; ay[2] = yhi_q; bx[2] = xlo_q; by[2] = yhi_q;
    ax[3] = xlo_q; ay[3] = ylo_q; bx[3] = xlo_q; by[3] = yhi_q;
    eps = wide_t'((eps_q == 0) ? 17'd1 : eps_q) <<< 16;
    for (int i = 0; i < 4; i++) begin
      num = (wide_t'(ln.px) - ax[i]) * wide_t'(ln.dx) + (wide_t'(ln.py) - ay[i]) * wide_t'(ln.dy);
      den = (bx[i] - ax[i]) * wide_t'(ln.dx) + (by[i] - ay[i]) * wide_t'(ln.dy);
      if (den <= eps && den >= -eps) den = (den < 0) ? -eps : eps;
      hx  = interpolate(ax[i][31:0], num, bx[i] - ax[i], den);
      hy  = interpolate(ay[i][31:0], num, by[i] - ay[i], den);
      hit = (num == 0) || ((num < 0) == (den < 0) &&
            ((num < 0) ? -num : num) <= ((den < 0) ? -den : den));
      if (hit) begin
        if (res.hits == 0) begin
          res.x1 = hx;
          res.y1 = hy;
        end else begin
          res.x2 = hx;
          res.y2 = hy;
        end
        res.hits++;
      end
    end
    res.both = (res.hits >= 2);
    return res;
  endfunction

  // Random coordinate: mostly near the rectangle, sometimes anywhere.
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'(signed'($urandom_range(0, 262144)) - 131072);
      default: return 32'(signed'($urandom_range(0, 98304)) - 16384);
    endcase
  endfunction

  function automatic line_t pick_line();
    line_t ln;
    ln.px = pick_coord();
    ln.py = pick_coord();
    case ($urandom_range(0, 5))
      0: begin ln.dx = $urandom(); ln.dy = $urandom(); end
      1: begin ln.dx = 0; ln.dy = pick_coord(); end
      2: begin ln.dx = pick_coord(); ln.dy = 0; end
      3: begin ln.dx = $urandom_range(0, 8) - 4; ln.dy = $urandom_range(0, 8) - 4; end
      default: begin ln.dx = pick_coord(); ln.dy = pick_coord(); end
    endcase
    return ln;
  endfunction

  // Writes one configuration register and mirrors it in the shadow copy.
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgRectXLow:  xlo_q = value;
      CfgRectXHigh: xhi_q = value;
      CfgRectYLow:  ylo_q = value;
      CfgRectYHigh: yhi_q = value;
      CfgDenEps:    eps_q = value[16:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_rect(input logic [31:0] xl, input logic [31:0] xh,
                            input logic [31:0] yl, input logic [31:0] yh,
                            input logic [31:0] e);
    write_reg(CfgRectXLow, xl);
    write_reg(CfgRectXHigh, xh);
    write_reg(CfgRectYLow, yl);
    write_reg(CfgRectYHigh, yh);
    write_reg(CfgDenEps, e);
  endtask

  // Waits until every queued line has been taken and every result checked.
  task automatic drain();
    while (pending_lines.size() != 0 || expected_crossings.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  task automatic queue_line(input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [31:0] dx, input logic signed [31:0] dy);
    line_t ln;
    ln.px = px; ln.py = py; ln.dx = dx; ln.dy = dy;
    pending_lines.push_back(ln);
  endtask

  // Sender: offers the oldest pending line, with random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_q) begin
        if (pending_lines.size() != 0) void'(pending_lines.pop_front());
      end
      if (pending_lines.size() != 0 && (quiet_sender || $urandom_range(0, 99) >= 7)) begin
        in_valid_i <= 1'b1;
        pivot_x_i  <= pending_lines[0].px;
        pivot_y_i  <= pending_lines[0].py;
        dir_x_i    <= pending_lines[0].dx;
        dir_y_i    <= pending_lines[0].dy;
      end else if (!(in_valid_i && in_stall_q)) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Acceptance is decided at the rising edge; the sender reads the registered copy on the falling edge.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      expected_crossings.push_back(clip_line(pending_lines[0]));
    end
    in_stall_q <= !(in_valid_i && !in_stall_o);
  end

  // Receiver stall pattern, with one long hold-off counted here.
  always @(negedge clk_i) begin
    if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall_i <= (hold_left != 0) || (!quiet_receiver && $urandom_range(0, 99) < 7);
  end

  // Result checker.
  always @(posedge clk_i) begin
    crossing_t exp_c;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_crossings.size() == 0) begin
        $display("%0t: unexpected result hits=%0d", $time, hit_count_o);
        error_count++;
      end else begin
        exp_c = expected_crossings.pop_front();
        if (both_found_o !== exp_c.both)
          $display("%0t: both_found expected %0d actual %0d", $time, exp_c.both, both_found_o);
        if (hit_count_o !== exp_c.hits)
          $display("%0t: hit_count expected %0d actual %0d", $time, exp_c.hits, hit_count_o);
        if (first_x_o !== exp_c.x1)
          $display("%0t: first_x expected %0d actual %0d", $time, exp_c.x1, first_x_o);
        if (first_y_o !== exp_c.y1)
          $display("%0t: first_y expected %0d actual %0d", $time, exp_c.y1, first_y_o);
        if (second_x_o !== exp_c.x2)
          $display("%0t: second_x expected %0d actual %0d", $time, exp_c.x2, second_x_o);
        if (second_y_o !== exp_c.y2)
          $display("%0t: second_y expected %0d actual %0d", $time, exp_c.y2, second_y_o);
        if ({both_found_o, hit_count_o, first_x_o, first_y_o, second_x_o, second_y_o}
            !== exp_c)
          error_count++;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = CfgRectXLow; cfg_data_i = '0;
    pivot_x_i = '0; pivot_y_i = '0; dir_x_i = '0; dir_y_i = '0;
    quiet_sender = 0; quiet_receiver = 0; hold_request = 0;
    xlo_q = 0; xhi_q = 65536; ylo_q = 0; yhi_q = 65536; eps_q = 1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed lines against the reset rectangle: corners, diagonals, zero normal, extremes.
    queue_line(32768, 32768, 65536, 0);
    queue_line(32768, 32768, 0, 65536);
    queue_line(0, 0, 65536, 65536);
    queue_line(0, 0, 65536, -65536);
    queue_line(65536, 65536, 1, -1);
    queue_line(200000, 200000, 65536, 0);
    queue_line(0, 0, 0, 0);
    queue_line(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    queue_line(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    queue_line(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    queue_line(-1, -1, -1, 1);
    queue_line(32768, 0, 1, 0);
    drain();

    // Zero epsilon with an inverted rectangle, then the widest rectangle with epsilon 65536.
    write_rect(65536, 0, 65536, 0, 0);
    queue_line(32768, 32768, 65536, 0);
    queue_line(0, 0, 65536, 65536);
    queue_line(32768, 32768, 3, 5);
    drain();
    write_rect(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 65536);
    queue_line(0, 0, 65536, 0);
    queue_line(0, 0, 32'sh7fffffff, 32'sh80000000);
    queue_line(32'sh7fffffff, 0, 1, 1);
    queue_line(12345, -54321, 2, 3);
    drain();

    // Random phases over several rectangle settings, with one long receiver hold-off.
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 0) write_rect(0, 65536, 0, 65536, 1);
      else if (phase == 4) write_rect($urandom(), $urandom(), $urandom(), $urandom(),
                                      $urandom_range(1, 65536));
      else write_rect(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                      $urandom_range(0, 65536));
      quiet_sender   = (phase == 2);
      quiet_receiver = (phase == 2);
      for (int k = 0; k < 200; k++) pending_lines.push_back(pick_line());
      if (phase == 1) begin
        repeat (20) @(posedge clk_i);
        hold_request = 1;
      end
      drain();
    end
    quiet_sender = 0;
    quiet_receiver = 0;

    if (error_count == 0 && expected_crossings.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/lrcp_pkg.sv
rtl/lrcp_front.sv
rtl/lrcp_queue.sv
rtl/lrcp_edge.sv
rtl/lrcp_back.sv
rtl/line_rectangle_clip_points_top.sv
verif/tb_top.sv
